// ----- rtl/sbu_pkg.sv -----
// sbu_pkg: shared types and constants of the seven-bit unpacker
// no dependencies
package sbu_pkg;

	localparam int FRAME_MAX = 7;
	localparam int BYTE_W    = 8;
	localparam int CNT_W     = 3;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} sbu_state_t;

	// read in flight toward the output register
	typedef struct packed {
		logic valid;
		logic msb;
		logic last;
		logic done;
	} rd_tag_t;

endpackage

// ----- rtl/sbu_ram.sv -----
// sbu_ram: generic one-write one-read ram with registered read data
// no dependencies
module sbu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 7
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/sbu_ctrl.sv -----
// sbu_ctrl: frame fill and drain sequencer, drives the frame ram
// depends on sbu_pkg
module sbu_ctrl import sbu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,
	input  logic              s_tlast,
	input  logic              out_free,
	output logic              ram_we,
	output logic [CNT_W-1:0]  ram_waddr,
	output logic [CNT_W-1:0]  ram_raddr,
	output rd_tag_t           tag_s1
);

	sbu_state_t state_q, state_d;
	logic [CNT_W-1:0]  held_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  idx_q;
	logic [BYTE_W-2:0] ovf_q;
	logic              end_q;
	logic              accept, full, take_ovf, issue, last_rd;
	logic [CNT_W-1:0]  bit_sel;

	assign accept   = s_tvalid && s_tready;
	assign full     = (held_q == CNT_W'(FRAME_MAX));
	assign take_ovf = full || (s_tlast && (held_q != '0));
	assign last_rd  = ((idx_q + CNT_W'(1)) == n_q);
	assign bit_sel  = CNT_W'(FRAME_MAX - 1) - idx_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (accept && take_ovf) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (issue && last_rd) begin
					state_d = ST_FILL;
				end
			end
			default: state_d = ST_FILL;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		issue     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = held_q;
		ram_raddr = idx_q;
		case (state_q)
			ST_FILL: begin
				s_tready = 1'b1;
				ram_we   = s_tvalid && !take_ovf && !s_tlast;
			end
			ST_DRAIN: begin
				issue = !tag_s1.valid && out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			held_q  <= '0;
			n_q     <= '0;
			idx_q   <= '0;
			tag_s1  <= '0;
		end else begin
			state_q      <= state_d;
			tag_s1.valid <= issue;
			if (ram_we) begin
				held_q <= held_q + CNT_W'(1);
			end
			if (accept && take_ovf) begin
				n_q    <= held_q;
				idx_q  <= '0;
				held_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (issue) begin
				tag_s1.msb  <= ovf_q[bit_sel];
				tag_s1.last <= last_rd;
				tag_s1.done <= last_rd && end_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && take_ovf) begin
			ovf_q <= s_tdata[BYTE_W-2:0];
			end_q <= s_tlast;
		end
	end

	a_no_accept_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> !s_tready)
		else $error("input taken while draining");

	a_issue_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> !issue)
		else $error("back-to-back ram reads");

	a_last_ends_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && last_rd) |=> (state_q == ST_FILL) && (held_q == '0))
		else $error("drain did not return to fill");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (n_q != '0) && (idx_q < n_q))
		else $error("drain index out of frame");

endmodule

// ----- rtl/sbu_out.sv -----
// sbu_out: output register merging recovered msb into ram read data
// depends on sbu_pkg
module sbu_out import sbu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rd_tag_t           tag_s1,
	input  logic [BYTE_W-1:0] rdata,
	output logic              out_free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,
	output logic              m_tlast,
	output logic              m_tuser
);

	logic valid_q;

	assign out_free = !valid_q || m_tready;
	assign m_tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (tag_s1.valid) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s1.valid) begin
			m_tdata <= rdata | {tag_s1.msb, {(BYTE_W-1){1'b0}}};
			m_tlast <= tag_s1.last;
			m_tuser <= tag_s1.done;
		end
	end

	a_land_free: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.valid |-> (!valid_q || m_tready))
		else $error("read data lands on an untaken item");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && m_tuser) |-> m_tlast)
		else $error("stream end without run end");

	a_tag_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_s1.valid && tag_s1.done) |-> tag_s1.last)
		else $error("tag done without last");

endmodule

// ----- rtl/seven_bit_unpacker_unit.sv -----
// seven_bit_unpacker_unit: top level of the 7-bit packed stream decoder
// depends on sbu_pkg, sbu_ram, sbu_ctrl, sbu_out
//
// channel  dir  tdata          tlast        tuser
// s_*      in   enc_byte[7:0]  stream_end   -
// m_*      out  dec_byte[7:0]  run_last     stream_done
//
// a data byte is taken and written to the frame ram
// an overflow byte starts a drain: decoded items leave one at a time, paced by
// the single ram read port and its registered read data; input waits meanwhile
// a full frame holds seven items and drains after its overflow byte
// arst_n clears the fill count and control; the ram needs no clearing
// output stalls hold the item in the output register and pause the drain
module seven_bit_unpacker_unit import sbu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // enc_byte
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,   // dec_byte
	output logic              m_tlast,
	output logic              m_tuser    // stream_done
);

	logic              ram_we;
	logic [CNT_W-1:0]  ram_waddr, ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;
	logic              out_free;
	rd_tag_t           tag_s1;

	sbu_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(FRAME_MAX)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(s_tdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	sbu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.out_free (out_free),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_raddr(ram_raddr),
		.tag_s1   (tag_s1)
	);

	sbu_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s1  (tag_s1),
		.rdata   (ram_rdata),
		.out_free(out_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

// ----- sim/tb_seven_bit_unpacker_unit.sv -----
// tb_seven_bit_unpacker_unit: self-checking stream testbench for the seven-bit unpacker
// drives encoded bytes with random gaps, predicts decoded items, checks them in order
// depends on sbu_pkg and seven_bit_unpacker_unit
module tb_seven_bit_unpacker_unit;
	import sbu_pkg::*;

	localparam int CYCLE_LIMIT = 40000;
	localparam int RAND_ITEMS  = 160;

	typedef struct {
		logic [BYTE_W-1:0] enc;
		logic              fin;
	} enc_item_t;

	typedef struct {
		logic [BYTE_W-1:0] dec;
		logic              run_last;
		logic              done;
	} dec_item_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata  = '0;   // enc_byte
	logic              s_tlast  = 1'b0; // stream_end
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [BYTE_W-1:0] m_tdata;         // dec_byte
	logic              m_tlast;         // run_last
	logic              m_tuser;         // stream_done

	enc_item_t         pending_q[$];
	dec_item_t         decoded_q[$];
	logic [BYTE_W-1:0] frame_buf[FRAME_MAX];
	int                held_n   = 0;
	int                sent_n   = 0;
	int                got_n    = 0;
	int                errors   = 0;
	int                cyc      = 0;

	seven_bit_unpacker_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// flush held bytes, each restored with its msb from the overflow byte
	task automatic drain_frame(input logic [BYTE_W-1:0] ovf, input logic at_end);
		dec_item_t d;
		for (int k = 0; k < held_n; k++) begin
			d.dec      = frame_buf[k] | {ovf[6-k], 7'b0};
			d.run_last = (k == held_n - 1);
			d.done     = (k == held_n - 1) && at_end;
			decoded_q.push_back(d);
		end
		held_n = 0;
	endtask

	task automatic predict_item(input enc_item_t it);
		if (held_n >= FRAME_MAX) begin
			drain_frame(it.enc, it.fin);
		end else if (it.fin) begin
			if (held_n != 0)
				drain_frame(it.enc, 1'b1);
		end else begin
			frame_buf[held_n] = it.enc;
			held_n++;
		end
	endtask

	task automatic push_item(input logic [BYTE_W-1:0] b, input logic fin);
		enc_item_t it;
		it.enc = b;
		it.fin = fin;
		pending_q.push_back(it);
	endtask

	task automatic add_frame(input int n, input logic fin);
		for (int i = 0; i < n; i++)
			push_item(BYTE_W'($urandom_range(255)), 1'b0);
		push_item(BYTE_W'($urandom_range(255)), fin);
	endtask

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("tb_seven_bit_unpacker_unit: FAIL");
			$finish;
		end
	end

	// driver: holds an item until accepted, then idles at random
	always @(posedge clk) begin : drive
		enc_item_t it;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				it = pending_q.pop_front();
				predict_item(it);
				sent_n++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_q.size() > 0 &&
				    ((sent_n >= 70 && sent_n < 120) || $urandom_range(99) >= 12)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_q[0].enc;
					s_tlast  <= pending_q[0].fin;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each accepted item against the oldest prediction
	always @(posedge clk) begin : watch
		dec_item_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_n++;
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected item dec_byte=%h run_last=%b stream_done=%b",
						$time, m_tdata, m_tlast, m_tuser);
					errors++;
				end else begin
					want = decoded_q.pop_front();
					if (m_tdata !== want.dec) begin
						$display("%0t: dec_byte expected %h actual %h", $time, want.dec, m_tdata);
						errors++;
					end
					if (m_tlast !== want.run_last) begin
						$display("%0t: run_last expected %b actual %b",
							$time, want.run_last, m_tlast);
						errors++;
					end
					if (m_tuser !== want.done) begin
						$display("%0t: stream_done expected %b actual %b",
							$time, want.done, m_tuser);
						errors++;
					end
				end
			end
			m_tready <= (got_n >= 60 && got_n < 110) || ($urandom_range(99) >= 12);
		end
	end

	initial begin : stim
		int n;
		int items_n;
		// full frame, mixed data msbs
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h80, 1'b0);
		push_item(8'h7F, 1'b0);
		push_item(8'h55, 1'b0);
		push_item(8'hAA, 1'b0);
		push_item(8'h01, 1'b0);
		push_item(8'h2A, 1'b0);
		// end marker with nothing held
		push_item(8'h5C, 1'b1);
		// one-byte partial frame, overflow bit 7 set
		push_item(8'h3C, 1'b0);
		push_item(8'hFF, 1'b1);
		// six-byte partial frame
		push_item(8'h11, 1'b0);
		push_item(8'h22, 1'b0);
		push_item(8'h33, 1'b0);
		push_item(8'hC4, 1'b0);
		push_item(8'hD5, 1'b0);
		push_item(8'hE6, 1'b0);
		push_item(8'h00, 1'b1);
		// full frame closed by an end-flagged overflow byte
		add_frame(7, 1'b1);

		items_n = 0;
		while (items_n < RAND_ITEMS) begin
			if ($urandom_range(9) == 0) begin
				push_item(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
				items_n++;
			end else begin
				n = $urandom_range(FRAME_MAX);
				add_frame(n, (n == FRAME_MAX) ? 1'($urandom_range(1)) : 1'b1);
				items_n += n + 1;
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_q.size() > 0 || s_tvalid)
			@(posedge clk);
		while (decoded_q.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb_seven_bit_unpacker_unit: PASS");
		else
			$display("tb_seven_bit_unpacker_unit: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/sbu_pkg.sv
rtl/sbu_ram.sv
rtl/sbu_ctrl.sv
rtl/sbu_out.sv
rtl/seven_bit_unpacker_unit.sv
sim/tb_seven_bit_unpacker_unit.sv
